>>> src/bvt_pkg.sv
// Shared types, codes and field widths for the bounded vector table.
`timescale 1ns / 1ps

package bvt_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 7;
    localparam int ITEM_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int FIDX_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    localparam logic [FIDX_W-1:0] FOUND_NONE = {FIDX_W{1'b1}};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_INSERT  = 3'd1,
        OP_PREPEND = 3'd2,
        OP_POP     = 3'd3,
        OP_DELETE  = 3'd4,
        OP_REMOVE  = 3'd5,
        OP_FIND    = 3'd6,
        OP_READ    = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // what the walk does with each word it reads back
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_INS    = 3'd1,
        K_DEL    = 3'd2,
        K_READ   = 3'd3,
        K_REMOVE = 3'd4,
        K_FIND   = 3'd5
    } kind_t;

    typedef struct packed {
        logic accept;
        logic setup;
        logic walk;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_needed;
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

>>> src/bvt_ctrl.sv
// Sequencer for the bounded vector table: accept, setup, walk, drain, finish.
`timescale 1ns / 1ps

module bvt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output bvt_pkg::cmd_t  cmd,
    input  bvt_pkg::stat_t st
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_WALK   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = st.walk_needed ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (st.walk_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word is consumed this cycle
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = st.out_free;
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/bvt_dp.sv
// Datapath for the bounded vector table: entry memory, walk pointer, result register.
`timescale 1ns / 1ps

module bvt_dp #(
    parameter int CAPACITY   = bvt_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bvt_pkg::DEF_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bvt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bvt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  bvt_pkg::cmd_t                  cmd,
    output bvt_pkg::stat_t                 st
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > bvt_pkg::POS_W) ? CW : bvt_pkg::POS_W;

    // entry memory, reset contents undefined
    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    bvt_pkg::opcode_t              op_reg;
    logic [bvt_pkg::POS_W-1:0]     pos_reg;
    logic [DATA_WIDTH-1:0]         w_reg;
    logic [CW-1:0]                 count_reg;

    bvt_pkg::kind_t                kind_reg, kind_next;
    bvt_pkg::status_t              status_reg, status_next;
    logic [AW-1:0]                 peff_reg, peff_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 end_reg, end_next;
    logic                          up_reg, up_next;
    logic                          need_next;

    logic                          rd_vld_reg;
    logic [AW-1:0]                 rd_addr_reg;
    logic [DATA_WIDTH-1:0]         rdata_reg;

    logic [CW-1:0]                 j_reg;
    logic [DATA_WIDTH-1:0]         val_reg;
    logic                          found_vld_reg;
    logic [AW-1:0]                 found_idx_reg;

    logic                          m_valid_reg;
    logic [bvt_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [DATA_WIDTH-1:0]         wdata;

    logic                          full, empty;
    logic [AW-1:0]                 c_m1;
    logic [XW-1:0]                 cx, px;
    logic                          match;
    logic [CW-1:0]                 cnt_fin;

    logic signed [63:0]            item_sx;
    logic signed [DATA_WIDTH-1:0]  val_s;
    logic signed [63:0]            val_sx;

    // ---- input capture ----
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= bvt_pkg::opcode_t'(s_tdata[2:0]);
            pos_reg <= s_tdata[9:3];
            w_reg   <= item_sx[DATA_WIDTH-1:0];
        end
    end

    assign item_sx = 64'(signed'(s_tdata[41:10]));

    // ---- operation decode against the current fill ----
    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    assign c_m1  = AW'(count_reg - CW'(1));
    assign cx    = XW'(count_reg);
    assign px    = XW'(pos_reg);

    always_comb begin
        kind_next   = bvt_pkg::K_NONE;
        status_next = bvt_pkg::ST_OK;
        peff_next   = '0;
        need_next   = 1'b0;
        unique case (op_reg)
            bvt_pkg::OP_PUSH: begin
                if (full) begin
                    status_next = bvt_pkg::ST_FULL;
                end else begin
                    kind_next = bvt_pkg::K_INS;
                    peff_next = AW'(count_reg);
                end
            end
            bvt_pkg::OP_INSERT: begin
                priority if (px > cx) begin
                    status_next = bvt_pkg::ST_RANGE;
                end else if (full) begin
                    status_next = bvt_pkg::ST_FULL;
                end else begin
                    kind_next = bvt_pkg::K_INS;
                    peff_next = AW'(pos_reg);
                end
            end
            bvt_pkg::OP_PREPEND: begin
                if (full) begin
                    status_next = bvt_pkg::ST_FULL;
                end else begin
                    kind_next = bvt_pkg::K_INS;
                end
            end
            bvt_pkg::OP_POP: begin
                if (empty) begin
                    status_next = bvt_pkg::ST_EMPTY;
                end else begin
                    kind_next = bvt_pkg::K_DEL;
                    peff_next = c_m1;
                end
            end
            bvt_pkg::OP_DELETE: begin
                if (px >= cx) begin
                    status_next = bvt_pkg::ST_RANGE;
                end else begin
                    kind_next = bvt_pkg::K_DEL;
                    peff_next = AW'(pos_reg);
                end
            end
            bvt_pkg::OP_REMOVE: begin
                kind_next = bvt_pkg::K_REMOVE;
            end
            bvt_pkg::OP_FIND: begin
                kind_next = bvt_pkg::K_FIND;
            end
            bvt_pkg::OP_READ: begin
                if (px >= cx) begin
                    status_next = bvt_pkg::ST_RANGE;
                end else begin
                    kind_next = bvt_pkg::K_READ;
                    peff_next = AW'(pos_reg);
                end
            end
            default: begin
                kind_next = bvt_pkg::K_NONE;
            end
        endcase

        ptr_next = '0;
        end_next = c_m1;
        up_next  = 1'b1;
        unique case (kind_next)
            bvt_pkg::K_INS: begin
                // shift the tail up, highest entry first
                need_next = (count_reg > CW'(peff_next));
                ptr_next  = c_m1;
                end_next  = peff_next;
                up_next   = 1'b0;
            end
            bvt_pkg::K_DEL: begin
                need_next = 1'b1;
                ptr_next  = peff_next;
            end
            bvt_pkg::K_READ: begin
                need_next = 1'b1;
                ptr_next  = peff_next;
                end_next  = peff_next;
            end
            bvt_pkg::K_REMOVE, bvt_pkg::K_FIND: begin
                need_next = !empty;
            end
            default: begin
                need_next = 1'b0;
            end
        endcase
    end

    assign st.walk_needed = need_next;
    assign st.walk_last   = (ptr_reg == end_reg);
    assign st.out_free    = !m_valid_reg || m_tready;

    // ---- walk pointer and read stage ----
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            peff_reg   <= peff_next;
            ptr_reg    <= ptr_next;
            end_reg    <= end_next;
            up_reg     <= up_next;
        end else if (cmd.walk) begin
            ptr_reg <= up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
        end
        rd_addr_reg <= ptr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.walk;
        end
    end

    // ---- processing of each word read back ----
    assign match = (rdata_reg == w_reg);

    always_comb begin
        we    = 1'b0;
        waddr = rd_addr_reg;
        wdata = rdata_reg;
        if (cmd.finish && kind_reg == bvt_pkg::K_INS) begin
            we    = 1'b1;
            waddr = peff_reg;
            wdata = w_reg;
        end else if (rd_vld_reg) begin
            unique case (kind_reg)
                bvt_pkg::K_INS: begin
                    we    = 1'b1;
                    waddr = rd_addr_reg + AW'(1);
                end
                bvt_pkg::K_DEL: begin
                    // first word read is the one taken out
                    we    = (rd_addr_reg != peff_reg);
                    waddr = rd_addr_reg - AW'(1);
                end
                bvt_pkg::K_REMOVE: begin
                    we    = !match;
                    waddr = j_reg[AW-1:0];
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.walk) begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            j_reg         <= '0;
            val_reg       <= '0;
            found_vld_reg <= 1'b0;
            found_idx_reg <= '0;
        end else if (rd_vld_reg) begin
            if ((kind_reg == bvt_pkg::K_DEL || kind_reg == bvt_pkg::K_READ)
                && rd_addr_reg == peff_reg) begin
                val_reg <= rdata_reg;
            end
            if (kind_reg == bvt_pkg::K_REMOVE && !match) begin
                j_reg <= j_reg + CW'(1);
            end
            if (kind_reg == bvt_pkg::K_FIND && match && !found_vld_reg) begin
                found_vld_reg <= 1'b1;
                found_idx_reg <= rd_addr_reg;
            end
        end
    end

    // ---- commit and result ----
    always_comb begin
        unique case (kind_reg)
            bvt_pkg::K_INS:    cnt_fin = count_reg + CW'(1);
            bvt_pkg::K_DEL:    cnt_fin = count_reg - CW'(1);
            bvt_pkg::K_REMOVE: cnt_fin = j_reg;
            default:           cnt_fin = count_reg;
        endcase
    end

    assign val_s  = val_reg;
    assign val_sx = 64'(val_s);

    always_comb begin
        m_data_next        = '0;
        m_data_next[31:0]  = val_sx[bvt_pkg::VALUE_W-1:0];
        m_data_next[38:32] = found_vld_reg ? bvt_pkg::FIDX_W'(found_idx_reg)
                                           : bvt_pkg::FOUND_NONE;
        m_data_next[45:39] = bvt_pkg::COUNT_W'(cnt_fin);
        m_data_next[46]    = (cnt_fin == '0);
        m_data_next[48:47] = status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                count_reg   <= cnt_fin;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> src/bounded_vector_table_core.sv
// Each word passes accept, setup, walk, drain and finish; walk and drain are skipped when
// no walk is needed (push, insert at the end, failed operations, remove or find on empty).
// Insert and prepend walk the entries from the position to the end, delete and pop
// those from the position up, read one entry, remove and find all entries.
// Throughput: one word at a time; the next word is accepted in the cycle after the result
// is loaded. Reset (aresetn low, synchronous): fill count zero, result channel empty,
// sequencer idle; memory contents are left as they are.
`timescale 1ns / 1ps

module bounded_vector_table_core #(
    parameter int CAPACITY   = bvt_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bvt_pkg::DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // opcode[2:0], position[9:3], item[41:10], zero pad
    input  logic [bvt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // value[31:0], found_index[38:32], count[45:39], empty_res[46], status[48:47], zero pad
    output logic [bvt_pkg::M_TDATA_W-1:0] m_tdata
);

    bvt_pkg::cmd_t  cmd;
    bvt_pkg::stat_t st;

    bvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    bvt_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

>>> sim/bvt_table_checker.sv
// Channel monitor for the bounded vector table: predicts each result word and compares it.
`timescale 1ns / 1ps

module bvt_table_checker
    import bvt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // opcode[2:0], position[9:3], item[41:10], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // value[31:0], found_index[38:32], count[45:39], empty_res[46], status[48:47], zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int CAP = DEF_CAPACITY;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [FIDX_W-1:0]  fidx;
        logic [COUNT_W-1:0] count;
        logic               empty;
        status_t            status;
    } table_result_t;

    logic [ITEM_W-1:0] shadow_entries [CAP];
    int                shadow_fill = 0;
    table_result_t     expected_q [$];
    int                fail_cnt = 0;
    int                pending_cnt = 0;

    assign fail_count  = fail_cnt;
    assign outstanding = pending_cnt;

    function automatic void place_word(int pos, logic [ITEM_W-1:0] w);
        int i;
        for (i = shadow_fill; i > pos; i--)
            shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos] = w;
        shadow_fill++;
    endfunction

    function automatic logic [ITEM_W-1:0] take_word(int pos);
        logic [ITEM_W-1:0] w;
        int i;
        w = shadow_entries[pos];
        for (i = pos; i + 1 < shadow_fill; i++)
            shadow_entries[i] = shadow_entries[i+1];
        shadow_fill--;
        return w;
    endfunction

    function automatic table_result_t table_step(opcode_t op, int pos, logic [ITEM_W-1:0] w);
        table_result_t r;
        int i;
        int j;
        r.value  = '0;
        r.fidx   = FOUND_NONE;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_fill >= CAP) r.status = ST_FULL;
                else place_word(shadow_fill, w);
            end
            OP_INSERT: begin
                // range check wins over full
                if (pos > shadow_fill) r.status = ST_RANGE;
                else if (shadow_fill >= CAP) r.status = ST_FULL;
                else place_word(pos, w);
            end
            OP_PREPEND: begin
                if (shadow_fill >= CAP) r.status = ST_FULL;
                else place_word(0, w);
            end
            OP_POP: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else r.value = take_word(shadow_fill - 1);
            end
            OP_DELETE: begin
                if (pos >= shadow_fill) r.status = ST_RANGE;
                else r.value = take_word(pos);
            end
            OP_REMOVE: begin
                j = 0;
                for (i = 0; i < shadow_fill; i++) begin
                    if (shadow_entries[i] != w) begin
                        shadow_entries[j] = shadow_entries[i];
                        j++;
                    end
                end
                shadow_fill = j;
            end
            OP_FIND: begin
                for (i = 0; i < shadow_fill; i++) begin
                    if (shadow_entries[i] == w) begin
                        r.fidx = FIDX_W'(i);
                        break;
                    end
                end
            end
            default: begin
                if (pos >= shadow_fill) r.status = ST_RANGE;
                else r.value = shadow_entries[pos];
            end
        endcase
        r.count = COUNT_W'(shadow_fill);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (aresetn) begin
            // a result word always belongs to an earlier operation, so compare first
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[31:0];
                got.fidx   = m_tdata[38:32];
                got.count  = m_tdata[45:39];
                got.empty  = m_tdata[46];
                got.status = status_t'(m_tdata[48:47]);
                if (expected_q.size() == 0) begin
                    $error("result word with no operation pending");
                    fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("value", want.value, got.value);
                    check_field("found_index", 32'(want.fidx), 32'(got.fidx));
                    check_field("count", 32'(want.count), 32'(got.count));
                    check_field("empty_res", 32'(want.empty), 32'(got.empty));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(table_step(opcode_t'(s_tdata[2:0]), int'(s_tdata[9:3]),
                                                s_tdata[41:10]));
            pending_cnt = expected_q.size();
        end
    end

endmodule

>>> sim/tb_bounded_vector_table_core.sv
// Stimulus and verdict for the bounded vector table core.
`timescale 1ns / 1ps

module tb_bounded_vector_table_core;
    import bvt_pkg::*;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } op_mix_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int words_sent = 0;
    int words_seen = 0;
    int level_hint = 0;

    logic [ITEM_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h5A5A_5A5A,
                                          32'h0000_0007, 32'hFFFF_FF9C};

    always #5 aclk = ~aclk;

    bounded_vector_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bvt_table_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // last reported count steers positions toward the live range
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_seen <= words_seen + 1;
            level_hint <= int'(m_tdata[45:39]);
        end
    end

    task automatic send_word(opcode_t op, logic [POS_W-1:0] pos, logic [ITEM_W-1:0] item);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OPCODE_W - POS_W - ITEM_W){1'b0}}, item, pos, op};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (words_seen != words_sent)
            @(negedge aclk);
    endtask

    function automatic opcode_t pick_op(op_mix_t mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW: begin
                if (r < 40) return OP_PUSH;
                if (r < 65) return OP_INSERT;
                if (r < 88) return OP_PREPEND;
                if (r < 94) return OP_FIND;
                return OP_READ;
            end
            MIX_SHRINK: begin
                if (r < 30) return OP_POP;
                if (r < 55) return OP_DELETE;
                if (r < 70) return OP_REMOVE;
                if (r < 85) return OP_READ;
                if (r < 95) return OP_FIND;
                return OP_PUSH;
            end
            default: return opcode_t'($urandom_range(7));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 70) return POS_W'($urandom_range(level_hint));
        if (r < 80) return POS_W'(level_hint + $urandom_range(1));
        return POS_W'($urandom_range(127));
    endfunction

    function automatic logic [ITEM_W-1:0] pick_item();
        // repeated values give find and remove something to match
        if ($urandom_range(1)) return value_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    task automatic run_phase(int n_words, int tx_pct, int rx_pct);
        int      left;
        int      seg;
        int      r;
        op_mix_t mix;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        left = n_words;
        // open with a long growth run so the table reaches full
        seg = 90;
        mix = MIX_GROW;
        while (left > 0) begin
            if (seg == 0) begin
                seg = $urandom_range(60, 20);
                r = $urandom_range(9);
                mix = (r < 4) ? MIX_SHRINK : (r < 7) ? MIX_ANY : MIX_GROW;
            end
            send_word(pick_op(mix), pick_pos(), pick_item());
            seg--;
            left--;
        end
        wait_drained();
    endtask

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 8;
        rx_idle_pct = 53;
        // empty-table corner cases
        send_word(OP_POP, 7'd0, 32'h0);
        send_word(OP_DELETE, 7'd0, 32'h0);
        send_word(OP_READ, 7'd0, 32'h0);
        send_word(OP_FIND, 7'd0, 32'h0);
        send_word(OP_REMOVE, 7'd0, 32'h0);
        send_word(OP_INSERT, 7'd1, 32'h1);
        // build a small table with extreme values
        send_word(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 7'd0, 32'h8000_0000);
        send_word(OP_PREPEND, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 7'd0, 32'h0);
        send_word(OP_READ, 7'd127, 32'h0);
        send_word(OP_READ, 7'd0, 32'h0);
        send_word(OP_READ, 7'd3, 32'h0);
        send_word(OP_INSERT, 7'd4, 32'h5555_5555);
        send_word(OP_INSERT, 7'd2, 32'hAAAA_AAAA);
        send_word(OP_FIND, 7'd0, 32'h8000_0000);
        send_word(OP_FIND, 7'd0, 32'h0000_3039);
        // non-adjacent duplicates, all removed in one pass
        send_word(OP_PUSH, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_REMOVE, 7'd0, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 7'd4, 32'h0);
        send_word(OP_DELETE, 7'd4, 32'h0);
        send_word(OP_DELETE, 7'd0, 32'h0);
        send_word(OP_INSERT, 7'd64, 32'h1234_5678);
        send_word(OP_POP, 7'd0, 32'h0);
        wait_drained();

        run_phase(480, 8, 53);
        run_phase(480, 53, 8);
        run_phase(470, 0, 0);

        // let any trailing walk finish before the verdict
        repeat (DEF_CAPACITY + 16) @(posedge aclk);
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
